### src/tgard_pkg.sv
`default_nettype none

package tgard_pkg;

   localparam int COUNT_BITS    = 30;
   localparam int CSR_DATA_BITS = COUNT_BITS;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BYTES_PER_PIXEL,
      CSR_RUN_LENGTH_CODED,
      CSR_ALPHA_IS_OPACITY,
      CSR_PIXEL_TOTAL
   } csr_index_type;

   typedef enum logic [1:0] {
      PIX_2B,
      PIX_3B,
      PIX_4B
   } pixel_size_type;

   typedef struct packed {
      logic [7:0]     b0;
      logic [7:0]     b1;
      logic [7:0]     b2;
      logic [7:0]     last;
      pixel_size_type size;
      logic           alpha_is_opacity;
      logic [7:0]     repeat_count;
      logic           image_complete;
      logic           truncated;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic pixel_size_type size_from_reg(input logic [2:0] v);
      pixel_size_type s;
      if (v inside {[3'd0:3'd2]}) begin
         s = PIX_2B;
      end else if (v == 3'd3) begin
         s = PIX_3B;
      end else begin
         s = PIX_4B;
      end
      return s;
   endfunction

   function automatic logic [1:0] last_position(input pixel_size_type s);
      logic [1:0] p;
      case (s)
         PIX_2B:  p = 2'd1;
         PIX_3B:  p = 2'd2;
         default: p = 2'd3;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

### src/tgard_ifs.sv
`default_nettype none

interface tgard_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface tgard_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] repeat_count;
   logic       image_complete;
   logic       truncated;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output repeat_count, output image_complete, output truncated,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input repeat_count, input image_complete, input truncated,
                   output ready);
endinterface

interface tgard_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tgard_pkg::CSR_INDEX_BITS-1:0] index;
   logic [tgard_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/tgard_front.sv
`default_nettype none

module tgard_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   tgard_req_if.sink                        req,
   tgard_csr_if.sink                        csr,
   input  wire tgard_pkg::queue_status_type q_status,
   output logic                             push,
   output tgard_pkg::entry_type             push_entry
);

   localparam int CB = tgard_pkg::COUNT_BITS;

   logic [2:0]    bpp_ff,   bpp_in;
   logic          rlc_ff,   rlc_in;
   logic          aop_ff,   aop_in;
   logic [CB-1:0] total_ff, total_in;

   logic          expect_ff,   expect_in;
   logic          is_run_ff,   is_run_in;
   logic [7:0]    left_ff,     left_in;
   logic [1:0]    pos_ff,      pos_in;
   logic [23:0]   partial_ff,  partial_in;
   logic [CB-1:0] remaining_ff, remaining_in;
   logic          finished_ff, finished_in;

   tgard_pkg::pixel_size_type size;
   logic          accept;
   logic          idle_image;
   logic          header;
   logic          pixel_done;
   logic          left_lt;
   logic [7:0]    rep;
   logic [CB-1:0] rem_next;
   logic          complete;
   logic [7:0]    left_after;

   assign req.ready = !q_status.full && !csr.valid;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   always_comb begin
      size       = tgard_pkg::size_from_reg(bpp_ff);
      idle_image = finished_ff || (remaining_ff == '0);
      header     = rlc_ff && expect_ff;
      pixel_done = !header && (pos_ff >= tgard_pkg::last_position(size));
      left_lt    = (remaining_ff[CB-1:8] != '0) || (left_ff < remaining_ff[7:0]);
      if (rlc_ff && is_run_ff) begin
         rep = left_lt ? left_ff : remaining_ff[7:0];
      end else begin
         rep = 8'd1;
      end
      rem_next   = remaining_ff - {{(CB-8){1'b0}}, rep};
      complete   = pixel_done && (rem_next == '0);
      left_after = is_run_ff ? 8'd0 : (left_ff - 8'd1);

      bpp_in       = bpp_ff;
      rlc_in       = rlc_ff;
      aop_in       = aop_ff;
      total_in     = total_ff;
      expect_in    = expect_ff;
      is_run_in    = is_run_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      partial_in   = partial_ff;
      remaining_in = remaining_ff;
      finished_in  = finished_ff;
      push         = 1'b0;

      push_entry.b0               = partial_ff[7:0];
      push_entry.b1               = partial_ff[15:8];
      push_entry.b2               = partial_ff[23:16];
      push_entry.last             = req.data_byte;
      push_entry.size             = size;
      push_entry.alpha_is_opacity = aop_ff;
      push_entry.repeat_count     = pixel_done ? rep : 8'd0;
      push_entry.image_complete   = complete;
      push_entry.truncated        = req.end_of_data && !complete;

      if (csr.valid) begin
         case (tgard_pkg::csr_index_type'(csr.index))
            tgard_pkg::CSR_BYTES_PER_PIXEL:  bpp_in   = csr.data[2:0];
            tgard_pkg::CSR_RUN_LENGTH_CODED: rlc_in   = csr.data[0];
            tgard_pkg::CSR_ALPHA_IS_OPACITY: aop_in   = csr.data[0];
            tgard_pkg::CSR_PIXEL_TOTAL:      total_in = csr.data[CB-1:0];
            default:                         bpp_in   = bpp_ff;
         endcase
         expect_in    = rlc_in;
         is_run_in    = 1'b0;
         left_in      = 8'd0;
         pos_in       = 2'd0;
         partial_in   = 24'd0;
         remaining_in = total_in;
         finished_in  = 1'b0;
      end else if (accept && !idle_image) begin
         if (header) begin
            is_run_in  = req.data_byte[7];
            left_in    = {1'b0, req.data_byte[6:0]} + 8'd1;
            expect_in  = 1'b0;
            pos_in     = 2'd0;
            partial_in = 24'd0;
         end else if (!pixel_done) begin
            case (pos_ff)
               2'd0:    partial_in[7:0]   = req.data_byte;
               2'd1:    partial_in[15:8]  = req.data_byte;
               default: partial_in[23:16] = req.data_byte;
            endcase
            pos_in = pos_ff + 2'd1;
         end else begin
            pos_in       = 2'd0;
            partial_in   = 24'd0;
            remaining_in = rem_next;
            if (rlc_ff) begin
               left_in = left_after;
               if (left_after == 8'd0) begin
                  expect_in = 1'b1;
               end
            end
            if (complete) begin
               finished_in = 1'b1;
            end
         end
         if (req.end_of_data && !complete) begin
            finished_in = 1'b1;
         end
         push = pixel_done || req.end_of_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= 3'd4;
         rlc_ff       <= 1'b1;
         aop_ff       <= 1'b0;
         total_ff     <= '0;
         expect_ff    <= 1'b1;
         is_run_ff    <= 1'b0;
         left_ff      <= 8'd0;
         pos_ff       <= 2'd0;
         partial_ff   <= 24'd0;
         remaining_ff <= '0;
         finished_ff  <= 1'b0;
      end else begin
         bpp_ff       <= bpp_in;
         rlc_ff       <= rlc_in;
         aop_ff       <= aop_in;
         total_ff     <= total_in;
         expect_ff    <= expect_in;
         is_run_ff    <= is_run_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         partial_ff   <= partial_in;
         remaining_ff <= remaining_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

`default_nettype wire

### src/tgard_queue.sv
`default_nettype none

module tgard_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tgard_pkg::entry_type push_entry,
   input  wire logic                 pop,
   output tgard_pkg::entry_type      head,
   output tgard_pkg::queue_status_type status
);

   tgard_pkg::entry_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = entries_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/tgard_back.sv
`default_nettype none

module tgard_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tgard_pkg::queue_status_type q_status,
   input  wire tgard_pkg::entry_type        head,
   output logic                             pop,
   tgard_rsp_if.source                      rsp
);

   logic       valid_ff, valid_in;
   logic [7:0] red_ff,   red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff,  blue_in;
   logic [7:0] alpha_ff, alpha_in;
   logic [7:0] rep_ff;
   logic       complete_ff;
   logic       truncated_ff;

   always_comb begin
      pop      = !q_status.empty && (!valid_ff || rsp.ready);
      valid_in = pop || (valid_ff && !rsp.ready);
      case (head.size)
         tgard_pkg::PIX_2B: begin
            red_in   = {head.last[6:2], 3'b000};
            green_in = {head.last[1:0], head.b0[7:5], 3'b000};
            blue_in  = {head.b0[4:0], 3'b000};
            alpha_in = {8{head.last[7] == head.alpha_is_opacity}};
         end
         tgard_pkg::PIX_3B: begin
            red_in   = head.last;
            green_in = head.b1;
            blue_in  = head.b0;
            alpha_in = 8'hFF;
         end
         default: begin
            red_in   = head.b2;
            green_in = head.b1;
            blue_in  = head.b0;
            alpha_in = head.alpha_is_opacity ? head.last : ~head.last;
         end
      endcase
      if (head.repeat_count == 8'd0) begin
         red_in   = 8'd0;
         green_in = 8'd0;
         blue_in  = 8'd0;
         alpha_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         alpha_ff     <= alpha_in;
         rep_ff       <= head.repeat_count;
         complete_ff  <= head.image_complete;
         truncated_ff <= head.truncated;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.red            = red_ff;
   assign rsp.green          = green_ff;
   assign rsp.blue           = blue_ff;
   assign rsp.alpha          = alpha_ff;
   assign rsp.repeat_count   = rep_ff;
   assign rsp.image_complete = complete_ff;
   assign rsp.truncated      = truncated_ff;

endmodule

`default_nettype wire

### src/tga_rle_pixel_decoder_top.sv
// TGA run-length pixel decoder. Feed the pixel-data bytes of an image on
// req_bus, one item per byte; the block takes one byte every cycle while its
// queue is not full and no csr_bus write is present, since the front stage
// updates its per-byte packet and pixel bookkeeping as each byte is taken.
// Each byte that completes a pixel, or that ends the data early, yields one
// RGBA item on rsp_bus once it has passed the two-entry queue and the output
// register; header bytes and bytes that only fill a pixel yield nothing. A
// run pixel carries its repeat count, raw and uncompressed pixels carry 1.
// Write csr_bus only while the block is idle; any write restarts the image.

`default_nettype none

module tga_rle_pixel_decoder_top (
   input wire logic  clock,
   input wire logic  reset,
   tgard_req_if.sink   req_bus,
   tgard_rsp_if.source rsp_bus,
   tgard_csr_if.sink   csr_bus
);

   tgard_pkg::queue_status_type q_status;
   tgard_pkg::entry_type        push_entry;
   tgard_pkg::entry_type        head;
   logic                        push;
   logic                        pop;

   tgard_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   tgard_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   tgard_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

   a_empty_item_is_truncated: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.repeat_count == 8'd0) |-> rsp_bus.truncated
   ) else $error("item without pixel lacks truncated flag");

   a_complete_excludes_truncated: assert property (
      @(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.image_complete && rsp_bus.truncated)
   ) else $error("item both complete and truncated");

   a_repeat_in_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.repeat_count <= 8'd128)
   ) else $error("repeat count above packet maximum");

   a_no_push_when_full: assert property (
      @(posedge clock) disable iff (reset)
      q_status.full |-> !push
   ) else $error("item pushed into full queue");

endmodule

`default_nettype wire

### tb/tgard_decode_checker.sv
module tgard_decode_checker (
   input wire logic  clock,
   input wire logic  reset,
   tgard_req_if      req_bus,
   tgard_rsp_if      rsp_bus,
   tgard_csr_if      csr_bus,
   output int unsigned fail_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import tgard_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       image_complete;
      logic       truncated;
   } pixel_item_t;

   logic [2:0]            bytes_per_pixel;
   logic                  run_length_coded;
   logic                  alpha_is_opacity;
   logic [COUNT_BITS-1:0] pixel_total;

   logic                  expect_header;
   logic                  packet_is_run;
   logic [7:0]            packet_left;
   logic [1:0]            byte_pos;
   logic [23:0]           partial;
   logic [COUNT_BITS-1:0] pixels_done;
   logic                  image_closed;

   pixel_item_t           pixel_q[$];
   int unsigned           mismatches;

   task automatic restart_image();
      expect_header = run_length_coded;
      packet_is_run = 0;
      packet_left   = 0;
      byte_pos      = 0;
      partial       = 0;
      pixels_done   = 0;
      image_closed  = 0;
   endtask

   task automatic report(input string what);
      $display("%0t: pixel mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eod,
                              output bit produced, output pixel_item_t px);
      int unsigned size;
      int unsigned remaining;
      int unsigned rep;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      bit          complete;
      produced = 0;
      px       = '0;
      rep      = 0;
      complete = 0;
      size = (bytes_per_pixel < 2) ? 2 : (bytes_per_pixel > 4) ? 4 : bytes_per_pixel;
      if (image_closed || pixels_done >= pixel_total) return;
      if (run_length_coded && expect_header) begin
         packet_is_run = b[7];
         packet_left   = {1'b0, b[6:0]} + 8'd1;
         expect_header = 0;
         byte_pos      = 0;
         partial       = 0;
      end else if (byte_pos + 1 < size) begin
         partial  = partial | (24'(b) << (8 * byte_pos));
         byte_pos = byte_pos + 2'd1;
      end else begin
         remaining = pixel_total - pixels_done;
         b0 = partial[7:0];
         b1 = partial[15:8];
         b2 = partial[23:16];
         case (size)
            2: begin
               px.red   = {b[6:2], 3'b000};
               px.green = {b[1:0], b0[7:5], 3'b000};
               px.blue  = {b0[4:0], 3'b000};
               px.alpha = (b[7] == alpha_is_opacity) ? 8'hFF : 8'h00;
            end
            3: begin
               px.red   = b;
               px.green = b1;
               px.blue  = b0;
               px.alpha = 8'hFF;
            end
            default: begin
               px.red   = b2;
               px.green = b1;
               px.blue  = b0;
               px.alpha = alpha_is_opacity ? b : ~b;
            end
         endcase
         byte_pos = 0;
         partial  = 0;
         if (run_length_coded) begin
            if (packet_is_run) begin
               rep = (packet_left < remaining) ? packet_left : remaining;
               packet_left = 0;
            end else begin
               rep = 1;
               packet_left = packet_left - 8'd1;
            end
            if (packet_left == 0) expect_header = 1;
         end else begin
            rep = 1;
         end
         pixels_done = pixels_done + COUNT_BITS'(rep);
         if (pixels_done >= pixel_total) begin
            complete     = 1;
            image_closed = 1;
         end
      end
      if (rep == 0 && !eod) return;
      if (eod && !complete) image_closed = 1;
      if (rep == 0) px = '0;
      px.repeat_count   = rep[7:0];
      px.image_complete = complete;
      px.truncated      = eod && !complete;
      produced = 1;
   endtask

   always @(posedge clock) begin : watch
      pixel_item_t fresh;
      pixel_item_t want;
      pixel_item_t got;
      bit          produced;
      if (reset) begin
         bytes_per_pixel  = 3'd4;
         run_length_coded = 1;
         alpha_is_opacity = 0;
         pixel_total      = 0;
         restart_image();
         pixel_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_BYTES_PER_PIXEL:  bytes_per_pixel  = csr_bus.data[2:0];
               CSR_RUN_LENGTH_CODED: run_length_coded = csr_bus.data[0];
               CSR_ALPHA_IS_OPACITY: alpha_is_opacity = csr_bus.data[0];
               CSR_PIXEL_TOTAL:      pixel_total      = csr_bus.data[COUNT_BITS-1:0];
               default: ;
            endcase
            restart_image();
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.data_byte, req_bus.end_of_data, produced, fresh);
            if (produced) pixel_q.push_back(fresh);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.alpha,
                    rsp_bus.repeat_count, rsp_bus.image_complete, rsp_bus.truncated};
            if (pixel_q.size() == 0) begin
               report("pixel item with nothing expected");
            end else begin
               want = pixel_q.pop_front();
               compare_field("red", got.red, want.red);
               compare_field("green", got.green, want.green);
               compare_field("blue", got.blue, want.blue);
               compare_field("alpha", got.alpha, want.alpha);
               compare_field("repeat_count", got.repeat_count, want.repeat_count);
               compare_field("image_complete", 8'(got.image_complete),
                             8'(want.image_complete));
               compare_field("truncated", 8'(got.truncated), 8'(want.truncated));
            end
         end
      end
      outstanding <= pixel_q.size();
      fail_count  <= mismatches;
   end

endmodule

### tb/tga_rle_pixel_decoder_top_test.sv
module tga_rle_pixel_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tgard_pkg::*;

   localparam int unsigned TARGET_BYTES    = 700;
   localparam int unsigned IMAGE_BYTE_CAP  = 160;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned DRAIN_CYCLES    = 10;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

   logic        clock = 0;
   logic        reset = 1;
   idle_mode_t  idle_mode = IDLE_NONE;
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned fail_count;
   int unsigned outstanding;

   tgard_req_if req_bus ();
   tgard_rsp_if rsp_bus ();
   tgard_csr_if csr_bus ();

   tga_rle_pixel_decoder_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tgard_decode_checker pixel_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned gap_pct(input idle_mode_t m, input bit receiver);
      case (m)
         IDLE_SENDER:   return receiver ? 0 : 83;
         IDLE_RECEIVER: return receiver ? 83 : 0;
         IDLE_BOTH:     return 27;
         default:       return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (holds_served != holds_asked) begin
         hold_left     <= HOLD_OFF_CYCLES - 1;
         holds_served  <= holds_served + 1;
         rsp_bus.ready <= 0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= gap_pct(idle_mode, 1));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tga_rle_pixel_decoder_top regression: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eod);
      while ($urandom_range(99) < gap_pct(idle_mode, 0)) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid       <= 1;
      req_bus.data_byte   <= b;
      req_bus.end_of_data <= eod;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic settle();
      req_bus.valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] v);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] bpp, input bit rlc, input bit aio,
                            input logic [COUNT_BITS-1:0] total);
      settle();
      write_reg(CSR_BYTES_PER_PIXEL, CSR_DATA_BITS'(bpp));
      write_reg(CSR_RUN_LENGTH_CODED, CSR_DATA_BITS'(rlc));
      write_reg(CSR_ALPHA_IS_OPACITY, CSR_DATA_BITS'(aio));
      write_reg(CSR_PIXEL_TOTAL, CSR_DATA_BITS'(total));
      csr_bus.valid <= 0;
   endtask

   // drop bytes past the budget; force the end flag on the cut byte
   task automatic put_byte(input logic [7:0] b, input logic eod, inout int unsigned sent,
                           input int unsigned cut);
      int unsigned budget;
      budget = (cut != 0) ? cut : IMAGE_BYTE_CAP;
      if (sent >= budget) return;
      send_byte(b, eod || (cut != 0 && sent + 1 == cut));
      sent++;
   endtask

   task automatic send_image(input int unsigned size, input bit rlc, input int unsigned total);
      int unsigned covered;
      int unsigned count;
      int unsigned npix;
      int unsigned sent;
      int unsigned cut;
      int unsigned p;
      int unsigned k;
      bit          run;
      bit          last_pkt;
      covered = 0;
      sent    = 0;
      cut     = ($urandom_range(99) < 15) ? $urandom_range(1, 40) : 0;
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(1, 30)) begin
            put_byte(8'($urandom), $urandom_range(99) < 5, sent, cut);
         end
         return;
      end
      while (covered < total && sent < ((cut != 0) ? cut : IMAGE_BYTE_CAP)) begin
         npix  = 1;
         count = 1;
         if (rlc) begin
            count = ($urandom_range(99) < 8) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            run   = $urandom_range(1);
            npix  = run ? 1 : count;
            put_byte({run, 7'(count - 1)}, 0, sent, cut);
         end
         covered += count;
         last_pkt = (covered >= total);
         for (p = 0; p < npix; p++) begin
            for (k = 0; k < size; k++) begin
               put_byte(8'($urandom),
                        last_pkt && p == npix - 1 && k == size - 1 && $urandom_range(1),
                        sent, cut);
            end
         end
      end
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom), $urandom_range(1), sent, cut);
   endtask

   initial begin
      logic [2:0]            bpp;
      logic [COUNT_BITS-1:0] total;
      int unsigned           size;
      int unsigned           phase;
      int unsigned           pick;
      bit                    rlc;
      req_bus.valid       = 0;
      req_bus.data_byte   = 0;
      req_bus.end_of_data = 0;
      rsp_bus.ready       = 0;
      csr_bus.valid       = 0;
      csr_bus.index       = CSR_BYTES_PER_PIXEL;
      csr_bus.data        = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // full-length run, raw pixel, then a run pixel that ends the data early
      configure(3'd2, 1, 1, 200);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h7F, 0);
      send_byte(8'h80, 0);
      send_byte(8'h00, 0);
      send_byte(8'h80, 1);
      send_byte(8'h55, 0);
      // uncompressed, trailing byte with end flag ignored
      configure(3'd3, 0, 0, 2);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_byte(8'hAA, 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h55, 0);
      send_byte(8'h12, 1);
      // oversize pixel setting, run clipped to the image
      configure(3'd7, 1, 0, 5);
      send_byte(8'h85, 0);
      send_byte(8'h11, 0);
      send_byte(8'h22, 0);
      send_byte(8'h33, 0);
      send_byte(8'hFE, 0);
      // empty image
      configure(3'd0, 1, 0, 0);
      send_byte(8'h3C, 1);
      // early end inside a pixel
      configure(3'd1, 1, 1, 10);
      send_byte(8'h01, 0);
      send_byte(8'h12, 1);
      send_byte(8'h34, 0);

      // hold the result side off so the block backs up into its input
      configure(3'd2, 0, 0, 60);
      holds_asked <= holds_asked + 1;
      repeat (120) send_byte(8'($urandom), 0);

      phase = 0;
      while (bytes_sent < TARGET_BYTES) begin
         idle_mode <= idle_mode_t'(phase % 4);
         bpp = ($urandom_range(99) < 80) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
         size = (bpp < 2) ? 2 : (bpp > 4) ? 4 : bpp;
         rlc = ($urandom_range(99) < 70);
         pick = $urandom_range(99);
         if (pick < 3) begin
            total = 0;
         end else if (pick < 5) begin
            total = 30'd1073676289;
         end else if (pick < 7) begin
            total = '1;
         end else if (pick < 10) begin
            total = COUNT_BITS'($urandom);
         end else if (pick < 30) begin
            total = $urandom_range(41, 300);
         end else begin
            total = $urandom_range(1, 40);
         end
         configure(bpp, rlc, $urandom_range(1), total);
         send_image(size, rlc, total);
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tga_rle_pixel_decoder_top regression: pass");
      end else begin
         $display("tga_rle_pixel_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
src/tgard_pkg.sv
src/tgard_ifs.sv
src/tgard_front.sv
src/tgard_queue.sv
src/tgard_back.sv
src/tga_rle_pixel_decoder_top.sv
tb/tgard_decode_checker.sv
tb/tga_rle_pixel_decoder_top_test.sv
